FILE: rtl/core/aerp_pkg.sv
// aerp_pkg: types and constants shared by the ARM ELF REL relocation patcher.
// No dependencies; imported by aerp_patch and arm_elf_reloc_patcher_top.
package aerp_pkg;

  // Relocation type codes (info word bits 7..0)
  localparam logic [7:0] TY_NONE   = 8'd0;
  localparam logic [7:0] TY_PC24   = 8'd1;
  localparam logic [7:0] TY_ABS32  = 8'd2;
  localparam logic [7:0] TY_CALL   = 8'd28;
  localparam logic [7:0] TY_JUMP24 = 8'd29;
  localparam logic [7:0] TY_V4BX   = 8'd40;
  localparam logic [7:0] TY_PREL31 = 8'd42;
  localparam logic [7:0] TY_MOVW   = 8'd43;
  localparam logic [7:0] TY_MOVT   = 8'd44;

  // Configuration register indexes
  localparam logic [1:0] CFG_TARGET_BASE  = 2'd0;
  localparam logic [1:0] CFG_TARGET_SIZE  = 2'd1;
  localparam logic [1:0] CFG_SYMBOL_COUNT = 2'd2;

  // Branch displacement window: bad when BRA_LO <= d <= BRA_HI (unsigned)
  localparam logic [31:0] BRA_LO    = 32'h0200_0000;
  localparam logic [31:0] BRA_HI    = 32'hfe00_0000;
  localparam logic [31:0] V4BX_KEEP = 32'hf000_000f;
  localparam logic [31:0] V4BX_SET  = 32'h01a0_f000;
  localparam logic [31:0] MOV_KEEP  = 32'hfff0_f000;
  localparam logic [31:0] PREL_MASK = 32'h7fff_ffff;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADSYM  = 3'd1,
    ST_BOUNDS  = 3'd2,
    ST_RANGE   = 3'd3,
    ST_UNKNOWN = 3'd4
  } aerp_status_e;

  // Stage 1: address formed, index and bounds checked
  typedef struct packed {
    logic [7:0]  rtype;
    logic        bad_sym;
    logic        bad_bounds;
    logic [31:0] addr;
    logic [31:0] word;
    logic [31:0] sym_val;
  } aerp_s1_t;

  // Stage 2: candidate sums for the ABS32, PREL31, branch and MOVW/MOVT families
  typedef struct packed {
    logic [7:0]  rtype;
    logic        bad_sym;
    logic        bad_bounds;
    logic [31:0] addr;
    logic [31:0] word;
    logic [31:0] abs_sum;
    logic [31:0] prel_sum;
    logic [31:0] bra_disp;
    logic [31:0] mov_sum;
  } aerp_s2_t;

  // Stage 3: finished result
  typedef struct packed {
    logic [31:0]  addr;
    logic [31:0]  word;
    aerp_status_e status;
  } aerp_res_t;

endpackage

FILE: rtl/core/aerp_patch.sv
// aerp_patch: stages 2 and 3 of the patcher (sums, then type select and checks).
// Depends on aerp_pkg; instantiated by arm_elf_reloc_patcher_top.
module aerp_patch (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s1_valid_i,
  input  aerp_pkg::aerp_s1_t s1_i,
  output logic               s1_ready_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output aerp_pkg::aerp_res_t res_o
);
  import aerp_pkg::*;

  logic      v2_q, v2_d, v3_q, v3_d;
  logic      adv2, adv3;
  aerp_s2_t  s2_q, s2_d;
  aerp_res_t s3_q, s3_d;

  logic [31:0] bra_add;
  logic [31:0] mov_add;
  logic        bra_bad;
  logic [15:0] mov_v;
  logic [31:0] word;

  // Stall chain: a stage takes new data when empty or when its successor moves
  assign adv3       = !v3_q || res_ready_i;
  assign adv2       = !v2_q || adv3;
  assign s1_ready_o = adv2;
  assign v2_d       = adv2 ? s1_valid_i : v2_q;
  assign v3_d       = adv3 ? v2_q : v3_q;

  // Stage 2: the adds
  always_comb begin
    bra_add = {{6{s1_i.word[23]}}, s1_i.word[23:0], 2'b00};
    mov_add = {{16{s1_i.word[19]}}, s1_i.word[19:16], s1_i.word[11:0]};
    s2_d.rtype      = s1_i.rtype;
    s2_d.bad_sym    = s1_i.bad_sym;
    s2_d.bad_bounds = s1_i.bad_bounds;
    s2_d.addr       = s1_i.addr;
    s2_d.word       = s1_i.word;
    s2_d.abs_sum    = s1_i.word + s1_i.sym_val;
    s2_d.prel_sum   = s1_i.word + s1_i.sym_val - s1_i.addr;
    s2_d.bra_disp   = bra_add + s1_i.sym_val - s1_i.addr;
    s2_d.mov_sum    = mov_add + s1_i.sym_val;
  end

  // Stage 3: pick by type, apply error priority
  always_comb begin
    word    = s2_q.word;
    bra_bad = (s2_q.bra_disp[1:0] != 2'b00) ||
              (s2_q.bra_disp >= BRA_LO && s2_q.bra_disp <= BRA_HI);
    mov_v   = (s2_q.rtype == TY_MOVT) ? s2_q.mov_sum[31:16] : s2_q.mov_sum[15:0];
    s3_d.addr   = s2_q.addr;
    s3_d.word   = word;
    s3_d.status = ST_OK;
    if (s2_q.bad_sym) begin
      s3_d.status = ST_BADSYM;
    end else if (s2_q.bad_bounds) begin
      s3_d.status = ST_BOUNDS;
    end else begin
      case (s2_q.rtype)
        TY_NONE: ;
        TY_ABS32: s3_d.word = s2_q.abs_sum;
        TY_PC24, TY_CALL, TY_JUMP24: begin
          if (bra_bad) begin
            s3_d.status = ST_RANGE;
          end else begin
            s3_d.word = {word[31:24], s2_q.bra_disp[25:2]};
          end
        end
        TY_V4BX:   s3_d.word = (word & V4BX_KEEP) | V4BX_SET;
        TY_PREL31: s3_d.word = s2_q.prel_sum & PREL_MASK;
        TY_MOVW, TY_MOVT: begin
          s3_d.word = (word & MOV_KEEP) | {12'h000, mov_v[15:12], 4'h0, mov_v[11:0]};
        end
        default: s3_d.status = ST_UNKNOWN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) s2_q <= s2_d;
    if (adv3) s3_q <= s3_d;
  end

  assign res_valid_o = v3_q;
  assign res_o       = s3_q;

  // Error priority: an index failure reaches the output as such
  a_badsym_wins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv3 && v2_q && s2_q.bad_sym) |=> (s3_q.status == ST_BADSYM))
    else $error("bad symbol index lost its priority");

  // Errors leave the word untouched
  a_err_keeps_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv3 && v2_q && (s2_q.bad_sym || s2_q.bad_bounds)) |=> (s3_q.word == $past(s2_q.word)))
    else $error("word changed on an error status");

  // A stalled result stays in place
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !res_ready_i) |=> (v3_q && $stable(s3_q)))
    else $error("stalled result moved");

endmodule

FILE: rtl/core/arm_elf_reloc_patcher_top.sv
// arm_elf_reloc_patcher_top: ARM ELF32 REL relocation patcher, three-stage pipeline.
// Depends on aerp_pkg and aerp_patch.
//
//  channel  | dir | payload (low bit first)
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | reloc_info[31:0], reloc_offset[31:0], original_word[31:0],
//           |     | symbol_value[31:0]
//  m_axis   | out | write_address[31:0], patched_word[31:0], status[2:0], 5'b0
//  cfg      | in  | 0 target_base(32), 1 target_size(32), 2 symbol_count(24)
//
// Rate: one request per cycle while m_axis is not stalled, through three register
// stages (stage 1 address/checks, stage 2 adds, stage 3 select/register). An
// accepted request moves through stages 1, 2, 3; in stage 3 it shows m_axis_tvalid and can leave.
// Reset clears the stage valid bits and the configuration registers to zero.
// Stalls: each stage holds while its successor is full and stalled, so a held
// output backs up stage by stage; s_axis_tready drops only when all three are full.
module arm_elf_reloc_patcher_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // reloc_info, reloc_offset, original_word, symbol_value
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata   // write_address, patched_word, status, zero pad
);
  import aerp_pkg::*;

  logic [31:0] base_q, size_q;
  logic [23:0] count_q;

  logic        v1_q, v1_d;
  logic        adv1, s1_ready;
  aerp_s1_t    s1_q, s1_d;
  aerp_res_t   res;

  logic [31:0] in_info, in_off, in_word, in_sym;
  logic [31:0] size_m4;

  assign in_info = s_axis_tdata[31:0];
  assign in_off  = s_axis_tdata[63:32];
  assign in_word = s_axis_tdata[95:64];
  assign in_sym  = s_axis_tdata[127:96];

  // Configuration registers; an out-of-list index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      size_q  <= '0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET_BASE:  base_q  <= cfg_data_i;
        CFG_TARGET_SIZE:  size_q  <= cfg_data_i;
        CFG_SYMBOL_COUNT: count_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Stage 1: write address, symbol index check (>= count, not >), bounds check
  always_comb begin
    size_m4         = size_q - 32'd4;
    s1_d.rtype      = in_info[7:0];
    s1_d.bad_sym    = in_info[31:8] >= count_q;
    s1_d.bad_bounds = (size_q < 32'd4) || (in_off > size_m4);
    s1_d.addr       = base_q + in_off;
    s1_d.word       = in_word;
    s1_d.sym_val    = in_sym;
  end

  assign adv1          = !v1_q || s1_ready;
  assign s_axis_tready = adv1;
  assign v1_d          = adv1 ? s_axis_tvalid : v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) s1_q <= s1_d;
  end

  // Stages 2 and 3
  aerp_patch u_patch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (v1_q),
    .s1_i        (s1_q),
    .s1_ready_o  (s1_ready),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {5'b0_0000, res.status, res.word, res.addr};

  // Ready low means every stage holds a request
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && m_axis_tvalid))
    else $error("input blocked with a free stage");

  // Stage 1 keeps its request while stage 2 cannot take it
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !s1_ready) |=> (v1_q && $stable(s1_q)))
    else $error("stage 1 request lost under stall");

  // Status codes stay within the defined set
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[66:64] <= 3'd4))
    else $error("undefined status code");

endmodule
